FILE: rtl/tap_pkg.sv
package tap_pkg;

    // Fixed channel sum width and channel field width
    localparam int unsigned TOTAL_W = 16;
    localparam int unsigned CHAN_W  = 8;

    // Pixel format codes
    localparam logic FMT_RGB565 = 1'b0;
    localparam logic FMT_XRGB32 = 1'b1;

    // Register indexes
    localparam logic REG_PIXEL_FORMAT = 1'b0;

    typedef struct packed {
        logic [TOTAL_W-1:0] red;
        logic [TOTAL_W-1:0] green;
        logic [TOTAL_W-1:0] blue;
    } tap_totals_t;

    typedef struct packed {
        logic busy;
        logic done;
    } tap_div_status_t;

    typedef enum logic [1:0] {
        CH_RED,
        CH_GREEN,
        CH_BLUE
    } tap_chan_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_WAIT,
        ST_EMIT
    } tap_state_t;

endpackage

FILE: rtl/tap_accum.sv
// Per-pixel unpack and saturating channel sums, plus pixel count.
module tap_accum #(
    parameter int unsigned MAX_TILE_PIXELS = 256,
    parameter int unsigned COUNT_W         = 9
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic                 clear,
    input  logic                 pixel_format,
    input  logic [31:0]          pixel_word,
    output tap_pkg::tap_totals_t totals,
    output logic [COUNT_W-1:0]   count
);

    tap_pkg::tap_totals_t totals_reg, totals_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic [tap_pkg::CHAN_W-1:0] r, g, b;
    logic                 room;

    function automatic logic [tap_pkg::TOTAL_W-1:0] sat_add(
        input logic [tap_pkg::TOTAL_W-1:0] total,
        input logic [tap_pkg::CHAN_W-1:0]  v
    );
        logic [tap_pkg::TOTAL_W:0] s;
        s = {1'b0, total} + {{(tap_pkg::TOTAL_W + 1 - tap_pkg::CHAN_W){1'b0}}, v};
        return s[tap_pkg::TOTAL_W] ? {tap_pkg::TOTAL_W{1'b1}} : s[tap_pkg::TOTAL_W-1:0];
    endfunction

    always_comb
    begin
        if (pixel_format == tap_pkg::FMT_RGB565)
        begin
            r = {3'b000, pixel_word[15:11]};
            g = {2'b00, pixel_word[10:5]};
            b = {3'b000, pixel_word[4:0]};
        end
        else
        begin
            r = pixel_word[31:24];
            g = pixel_word[23:16];
            b = pixel_word[15:8];
        end
    end

    assign room = (count_reg < COUNT_W'(MAX_TILE_PIXELS));

    always_comb
    begin
        totals_next = totals_reg;
        count_next  = count_reg;
        if (clear)
        begin
            totals_next = '0;
            count_next  = '0;
        end
        else if (accept && room)
        begin
            totals_next.red   = sat_add(totals_reg.red, r);
            totals_next.green = sat_add(totals_reg.green, g);
            totals_next.blue  = sat_add(totals_reg.blue, b);
            count_next        = count_reg + COUNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            totals_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            totals_reg <= totals_next;
            count_reg  <= count_next;
        end
    end

    assign totals = totals_reg;
    assign count  = count_reg;

endmodule

FILE: rtl/tap_divider.sv
// Restoring divider, one quotient bit per cycle.
module tap_divider #(
    parameter int unsigned COUNT_W = 9
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [tap_pkg::TOTAL_W-1:0]  dividend,
    input  logic [COUNT_W-1:0]           divisor,
    output logic [tap_pkg::TOTAL_W-1:0]  quotient,
    output tap_pkg::tap_div_status_t     status
);

    localparam int unsigned STEP_W = $clog2(tap_pkg::TOTAL_W);

    logic [COUNT_W-1:0]          rem_reg, rem_next;
    logic [tap_pkg::TOTAL_W-1:0] quo_reg, quo_next;
    logic [STEP_W-1:0]           step_reg, step_next;
    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [COUNT_W:0]            trial, diff;
    logic                        ge;

    assign trial = {rem_reg, quo_reg[tap_pkg::TOTAL_W-1]};
    assign diff  = trial - {1'b0, divisor};
    assign ge    = (trial >= {1'b0, divisor});

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            step_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? diff[COUNT_W-1:0] : trial[COUNT_W-1:0];
            quo_next  = {quo_reg[tap_pkg::TOTAL_W-2:0], ge};
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(tap_pkg::TOTAL_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign quotient    = quo_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

FILE: rtl/tile_average_pixelize.sv
// Mosaic tile averaging filter.
//
// Input channel (in_valid/in_stall): pixel_word plus tile_end, one pixel per
// transaction. Pixels of a tile arrive in order; tile_end marks the last one.
// Each channel is summed (saturating at 16 bits) and pixels counted; pixels
// past MAX_TILE_PIXELS in one tile are dropped from the sums.
// Output channel (out_valid/out_stall): one average_pixel per tile, the floor
// average repacked in the current pixel_format (RGB565, or 8-bit channels in
// bits 31..8 with bits 7..0 zero).
// Flow: ordinary pixels are accepted back to back while in_stall is low. After
// a tile_end pixel, in_stall stays high for three 16-step divisions (red,
// green, blue) on the single shared restoring divider, each made of a start,
// 16 steps and the capture of the quotient, then the load of the output
// register. The output register lets the next tile accumulate while the
// result waits; a stalled receiver only holds the block once the next tile's
// result is ready to load.
// Configuration: APB register 0 (byte address 0), bit 0 = pixel_format.
// Write it only while the block is idle.
// Reset (rst_n, asynchronous): sums, count, format and output valid clear.
module tile_average_pixelize #(
    parameter int unsigned MAX_TILE_PIXELS = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    // pixel stream
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] pixel_word,
    input  logic        tile_end,
    // averages
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] average_pixel,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int unsigned COUNT_W = $clog2(MAX_TILE_PIXELS + 1);

    tap_pkg::tap_state_t state_reg, state_next;
    tap_pkg::tap_chan_t  chan_reg, chan_next;

    logic                        fmt_reg;
    logic                        out_valid_reg, out_valid_next;
    logic [31:0]                 out_data_reg, out_data_next;
    logic [tap_pkg::CHAN_W-1:0]  avg_r_reg, avg_g_reg, avg_b_reg;
    logic [tap_pkg::CHAN_W-1:0]  avg_r_next, avg_g_next, avg_b_next;

    logic                        in_accept;
    logic                        clear;
    logic                        div_start;
    logic [tap_pkg::TOTAL_W-1:0] div_dividend;
    logic [tap_pkg::TOTAL_W-1:0] div_quotient;
    logic [tap_pkg::CHAN_W-1:0]  quo_masked;
    tap_pkg::tap_div_status_t    div_status;
    tap_pkg::tap_totals_t        totals;
    logic [COUNT_W-1:0]          count;
    logic [31:0]                 packed_avg;
    logic                        cfg_write;

    // APB: always ready, single register at index 0
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == tap_pkg::REG_PIXEL_FORMAT) ? {31'b0, fmt_reg} : 32'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fmt_reg <= tap_pkg::FMT_RGB565;
        else if (cfg_write && (paddr[2] == tap_pkg::REG_PIXEL_FORMAT))
            fmt_reg <= pwdata[0];
    end

    assign in_stall  = (state_reg != tap_pkg::ST_IDLE);
    assign in_accept = in_valid && !in_stall;

    tap_accum #(
        .MAX_TILE_PIXELS (MAX_TILE_PIXELS),
        .COUNT_W         (COUNT_W)
    ) u_accum (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (in_accept),
        .clear        (clear),
        .pixel_format (fmt_reg),
        .pixel_word   (pixel_word),
        .totals       (totals),
        .count        (count)
    );

    tap_divider #(
        .COUNT_W (COUNT_W)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (count),
        .quotient (div_quotient),
        .status   (div_status)
    );

    // empty-tile guard: zero count gives a zero average
    assign quo_masked = (count == '0) ? '0 : div_quotient[tap_pkg::CHAN_W-1:0];

    always_comb
    begin
        if (fmt_reg == tap_pkg::FMT_RGB565)
            packed_avg = {16'b0, avg_r_reg[4:0], avg_g_reg[5:0], avg_b_reg[4:0]};
        else
            packed_avg = {avg_r_reg, avg_g_reg, avg_b_reg, 8'b0};
    end

    // sequencer: walk the three channels through the shared divider
    always_comb
    begin
        state_next     = state_reg;
        chan_next      = chan_reg;
        avg_r_next     = avg_r_reg;
        avg_g_next     = avg_g_reg;
        avg_b_next     = avg_b_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && out_stall;
        div_start      = 1'b0;
        clear          = 1'b0;

        unique case (chan_reg)
            tap_pkg::CH_RED:   div_dividend = totals.red;
            tap_pkg::CH_GREEN: div_dividend = totals.green;
            tap_pkg::CH_BLUE:  div_dividend = totals.blue;
            default:           div_dividend = totals.blue;
        endcase

        unique case (state_reg)
            tap_pkg::ST_IDLE:
            begin
                if (in_accept && tile_end)
                begin
                    chan_next  = tap_pkg::CH_RED;
                    state_next = tap_pkg::ST_START;
                end
            end
            tap_pkg::ST_START:
            begin
                div_start  = 1'b1;
                state_next = tap_pkg::ST_WAIT;
            end
            tap_pkg::ST_WAIT:
            begin
                if (div_status.done)
                begin
                    unique case (chan_reg)
                        tap_pkg::CH_RED:
                        begin
                            avg_r_next = quo_masked;
                            chan_next  = tap_pkg::CH_GREEN;
                            state_next = tap_pkg::ST_START;
                        end
                        tap_pkg::CH_GREEN:
                        begin
                            avg_g_next = quo_masked;
                            chan_next  = tap_pkg::CH_BLUE;
                            state_next = tap_pkg::ST_START;
                        end
                        default:
                        begin
                            avg_b_next = quo_masked;
                            state_next = tap_pkg::ST_EMIT;
                        end
                    endcase
                end
            end
            tap_pkg::ST_EMIT:
            begin
                // wait for the output register to free up
                if (!out_valid_reg || !out_stall)
                begin
                    out_data_next  = packed_avg;
                    out_valid_next = 1'b1;
                    clear          = 1'b1;
                    state_next     = tap_pkg::ST_IDLE;
                end
            end
            default:
                state_next = tap_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tap_pkg::ST_IDLE;
            chan_reg      <= tap_pkg::CH_RED;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            chan_reg      <= chan_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        avg_r_reg    <= avg_r_next;
        avg_g_reg    <= avg_g_next;
        avg_b_reg    <= avg_b_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid     = out_valid_reg;
    assign average_pixel = out_data_reg;

endmodule

FILE: dv/tb.sv
module tb;

    localparam int unsigned MAX_TILE      = 256;
    // spare register slot: writes there must not touch anything
    localparam int unsigned REG_SPARE     = 1;
    // extra wait in settle() after the last owed average is in; allow some margin
    localparam int unsigned SETTLE_CYCLES = 70;
    localparam int unsigned HOLD_CYCLES   = 600;
    localparam int unsigned CYCLE_LIMIT   = 200000;
    localparam int unsigned PHASES        = 7;
    localparam int unsigned PHASE_ITEMS   = 12;

    // ------------------------------------------------------------------
    // Scoreboard: own copy of the sums, the count and the format, plus the
    // averages still owed by the block, oldest first.
    // ------------------------------------------------------------------
    class average_checker;
        logic        fmt;
        logic [15:0] red_sum;
        logic [15:0] green_sum;
        logic [15:0] blue_sum;
        logic [8:0]  pixel_count;
        logic [31:0] pending_averages[$];
        int unsigned faults;

        function new();
            fmt         = tap_pkg::FMT_RGB565;
            red_sum     = '0;
            green_sum   = '0;
            blue_sum    = '0;
            pixel_count = '0;
            faults      = 0;
        endfunction

        // first ten reported in full, the rest only counted
        function void note_fault(string msg);
            faults++;
            if (faults <= 10)
                $display("mismatch: %s", msg);
        endfunction

        function void write_reg(int unsigned index, logic [31:0] value);
            if (index == tap_pkg::REG_PIXEL_FORMAT)
                fmt = value[0];
        endfunction

        // saturating 16-bit channel accumulate
        function logic [15:0] sat_add(logic [15:0] total, logic [7:0] chan);
            logic [16:0] s;
            s = {1'b0, total} + {9'b0, chan};
            return s[16] ? 16'hFFFF : s[15:0];
        endfunction

        // accepted pixel transaction: accumulate, and on tile_end owe an average
        function void take_pixel(logic [31:0] px, logic last);
            logic [7:0]  r;
            logic [7:0]  g;
            logic [7:0]  b;
            logic [15:0] r_avg;
            logic [15:0] g_avg;
            logic [15:0] b_avg;
            logic [31:0] repacked;
            // pixels past the tile bound are dropped
            if (pixel_count < MAX_TILE) begin
                if (fmt == tap_pkg::FMT_RGB565) begin
                    r = {3'b0, px[15:11]};
                    g = {2'b0, px[10:5]};
                    b = {3'b0, px[4:0]};
                end
                else begin
                    r = px[31:24];
                    g = px[23:16];
                    b = px[15:8];
                end
                red_sum     = sat_add(red_sum, r);
                green_sum   = sat_add(green_sum, g);
                blue_sum    = sat_add(blue_sum, b);
                pixel_count = pixel_count + 9'd1;
            end
            if (last) begin
                if (pixel_count == 0) begin
                    r_avg = '0;
                    g_avg = '0;
                    b_avg = '0;
                end
                else begin
                    r_avg = red_sum / pixel_count;
                    g_avg = green_sum / pixel_count;
                    b_avg = blue_sum / pixel_count;
                end
                // packed with the format in force at the tile_end transaction
                if (fmt == tap_pkg::FMT_RGB565)
                    repacked = {16'b0, r_avg[4:0], g_avg[5:0], b_avg[4:0]};
                else
                    repacked = {r_avg[7:0], g_avg[7:0], b_avg[7:0], 8'b0};
                pending_averages.push_back(repacked);
                red_sum     = '0;
                green_sum   = '0;
                blue_sum    = '0;
                pixel_count = '0;
            end
        endfunction

        function void compare_average(logic [31:0] actual);
            logic [31:0] want;
            if (pending_averages.size() == 0) begin
                note_fault($sformatf("unexpected average %h", actual));
                return;
            end
            want = pending_averages.pop_front();
            if (actual !== want)
                note_fault($sformatf("average expected %h actual %h", want, actual));
        endfunction

        function int unsigned backlog();
            return pending_averages.size();
        endfunction
    endclass

    // ------------------------------------------------------------------
    // DUT and its connections
    // ------------------------------------------------------------------
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid;
    logic        in_stall;
    logic [31:0] pixel_word;
    logic        tile_end;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] average_pixel;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    tile_average_pixelize #(
        .MAX_TILE_PIXELS(MAX_TILE)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .pixel_word   (pixel_word),
        .tile_end     (tile_end),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .average_pixel(average_pixel),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    average_checker sb = new();

    // stimulus knobs shared between the sender and the receiver
    bit tx_quiet = 1'b0;   // sender offers back to back
    bit rx_quiet = 1'b0;   // receiver never stalls
    bit hold_req = 1'b0;   // one-off long receiver hold-off

    int unsigned cycle_count = 0;

    always #6 clk = ~clk;

    // Watchdog: a hang anywhere ends the run as a failure.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Monitor: both channels sampled at the rising edge, values were set up
    // at the previous falling edge.
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && !in_stall)
                sb.take_pixel(pixel_word, tile_end);
            if (out_valid && !out_stall)
                sb.compare_average(average_pixel);
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int unsigned idle_len();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [31:0] pick_pixel();
        case ($urandom_range(0, 15))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    // most tiles small, now and then a long one; short_only keeps them all short
    function automatic int unsigned tile_len(bit short_only);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (short_only || roll < 60)
            return $urandom_range(1, 4);
        if (roll < 90)
            return $urandom_range(5, 16);
        return $urandom_range(17, 64);
    endfunction

    // Receiver: stall runs of random length; one long hold when asked.
    initial begin : receiver
        bit          stall_v;
        int unsigned run;
        out_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                stall_v  = 1'b1;
                run      = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            else if (rx_quiet) begin
                stall_v = 1'b0;
                run     = 1;
            end
            else begin
                stall_v = ($urandom_range(0, 2) == 0);
                run     = idle_len();
                if (run == 0)
                    run = 1;
            end
            out_stall <= stall_v;
            repeat (run - 1) @(negedge clk);
        end
    end

    // One pixel transaction. Entered at a falling edge, left at a falling
    // edge; valid is only lowered when a gap follows, so it never drops and
    // rises in the same step.
    task automatic send_pixel(input logic [31:0] px, input logic last);
        int unsigned gap;
        in_valid   <= 1'b1;
        pixel_word <= px;
        tile_end   <= last;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
        gap = tx_quiet ? 0 : idle_len();
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic send_tile(input int unsigned len, input bit close);
        for (int unsigned i = 1; i <= len; i++)
            send_pixel(pick_pixel(), close && (i == len));
    endtask

    // Sender pause: wait until every owed average is in, then let the block
    // finish whatever it may still be doing.
    task automatic settle();
        in_valid <= 1'b0;
        while (sb.backlog() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // APB write (setup + access), then read back the format register.
    task automatic reg_write(input int unsigned index, input logic [31:0] value);
        logic [31:0] byte_addr;
        byte_addr = index * 4;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= byte_addr[2:0];
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        sb.write_reg(index, value);
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== {31'b0, sb.fmt})
            sb.note_fault($sformatf("pixel_format read expected %h actual %h",
                                    {31'b0, sb.fmt}, prdata));
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    initial begin : stimulus
        int unsigned sent;
        int unsigned len;
        bit          cut;
        logic [31:0] fmt_word;

        in_valid   = 1'b0;
        pixel_word = '0;
        tile_end   = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;

        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // --- directed: reset format is RGB565 -----------------------------
        send_pixel(32'hFFFF_FFFF, 1'b1);   // all channels full, upper half ignored
        send_pixel(32'h0000_0000, 1'b1);
        send_pixel(32'h0000_FFFF, 1'b0);   // floor rounding over three pixels
        send_pixel(32'h0000_0000, 1'b0);
        send_pixel(32'h0000_0841, 1'b1);
        settle();
        reg_write(REG_SPARE, 32'hFFFF_FFFF);   // spare slot, no effect
        send_pixel(32'hFFFF_F81F, 1'b1);
        settle();
        reg_write(tap_pkg::REG_PIXEL_FORMAT, 32'hFFFF_FFFF);   // only bit 0 kept -> 32-bit
        send_pixel(32'hFFFF_FFFF, 1'b1);   // low byte must come back zero
        send_pixel(32'h0000_00FF, 1'b1);
        send_pixel(32'hFF00_0000, 1'b0);
        send_pixel(32'h01FF_FFFF, 1'b0);
        send_pixel(32'h0000_0001, 1'b1);
        // format switched part-way through a tile, both directions
        send_pixel(32'hFFFF_FFFF, 1'b0);
        send_pixel(32'h8080_8080, 1'b0);
        settle();
        reg_write(tap_pkg::REG_PIXEL_FORMAT, 32'hFFFF_FFFE);
        send_pixel(32'h0000_FFFF, 1'b1);
        send_pixel(32'h0000_FFFF, 1'b0);
        send_pixel(32'h0000_1234, 1'b0);
        settle();
        reg_write(tap_pkg::REG_PIXEL_FORMAT, 32'h0000_0001);
        send_pixel(32'hABCD_EF01, 1'b1);
        settle();
        reg_write(REG_SPARE, 32'h0000_0000);
        send_pixel(32'h7F7F_7F7F, 1'b0);
        send_pixel(32'h8080_8080, 1'b1);

        // --- random phases -------------------------------------------------
        // Phase 0/1 pin both format extremes; a phase may stop mid-tile so
        // the next format change lands inside a tile.
        for (int unsigned p = 0; p < PHASES; p++) begin
            settle();
            fmt_word = $urandom() & ~32'h1;
            if (p == 0)
                fmt_word[0] = tap_pkg::FMT_RGB565;
            else if (p == 1)
                fmt_word[0] = tap_pkg::FMT_XRGB32;
            else
                fmt_word[0] = 1'($urandom_range(0, 1));
            reg_write(tap_pkg::REG_PIXEL_FORMAT, fmt_word);
            if ($urandom_range(0, 3) == 0)
                reg_write(REG_SPARE, $urandom());
            tx_quiet = (p == 2 || p == 4);
            rx_quiet = (p == 2 || p == 5);
            // long receiver hold while short tiles keep coming: block fills
            if (p == 4)
                hold_req = 1'b1;
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                len = tile_len(p == 4);
                cut = (sent + len >= PHASE_ITEMS) && ($urandom_range(0, 4) == 0);
                send_tile(len, !cut);
                sent += len;
            end
        end

        // --- tile bound: pixels past the limit dropped, incl. the tile_end one
        settle();
        fmt_word    = $urandom() & ~32'h1;
        fmt_word[0] = 1'($urandom_range(0, 1));
        reg_write(tap_pkg::REG_PIXEL_FORMAT, fmt_word);
        tx_quiet = 1'b1;
        rx_quiet = 1'b1;
        send_tile(MAX_TILE + 1, 1'b1);
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
        send_tile(3, 1'b1);

        settle();
        if (sb.faults == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
